### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// ante |=> cons, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/wft_pkg.sv
// Shared types, constants and control program of the wrench frame transform.
// Used by the datapath, the top level and the port checker; depends on nothing.
`default_nettype none

package wft_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CMP_W      = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [CMP_W-1:0] CNT_MAX = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int PC_W       = 5;
  localparam int RF_W       = 41;
  localparam int ACC_W      = 64;
  localparam int SPLIT      = 21;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 3'd4;

  localparam logic [47:0] ROT_ROW0_RST = 48'h4000_0000_0000;
  localparam logic [47:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST = 48'h0000_0000_4000;

  localparam logic [4:0] FRAC_FORCE  = 5'd14;
  localparam logic [4:0] FRAC_TORQUE = 5'd26;

  typedef struct packed {
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic signed [23:0] force_z;
    logic signed [23:0] torque_x;
    logic signed [23:0] torque_y;
    logic signed [23:0] torque_z;
    logic [31:0]        time_stamp;
    logic               same_frame;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
    logic signed [31:0] out_force_z;
    logic signed [31:0] out_torque_x;
    logic signed [31:0] out_torque_y;
    logic signed [31:0] out_torque_z;
    logic [31:0]        out_stamp;
    logic [15:0]        sample_index;
    logic               last_sample;
  } out_t;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} seq_state_t;

  typedef enum logic [3:0] {
    A_R00, A_R01, A_R02, A_R10, A_R11, A_R12, A_R20, A_R21, A_R22,
    A_P0, A_P1, A_P2
  } a_sel_t;

  typedef enum logic [3:0] {
    B_F0, B_F1, B_F2, B_M0, B_M1, B_M2,
    B_LO0, B_LO1, B_LO2, B_HI0, B_HI1, B_HI2
  } b_sel_t;

  typedef enum logic [2:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LDRM} acc_op_t;
  typedef enum logic [1:0] {STO_NONE, STO_RF, STO_RM, STO_TQ} sto_op_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_BYP, SEQ_DONE} seq_op_t;

  typedef struct packed {
    a_sel_t          a;
    b_sel_t          b;
    acc_op_t         acc;
    logic [1:0]      acc_idx;
    sto_op_t         sto;
    logic [1:0]      sto_idx;
    seq_op_t         seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam ucode_t UW_IDLE = '{a: A_R00, b: B_F0, acc: ACC_NOP, acc_idx: 2'd0,
                                 sto: STO_NONE, sto_idx: 2'd0, seq: SEQ_NEXT,
                                 target: '0};

  function automatic ucode_t uw(input a_sel_t a, input b_sel_t b, input acc_op_t acc,
                                input logic [1:0] ai, input sto_op_t sto,
                                input logic [1:0] si, input seq_op_t seq,
                                input logic [PC_W-1:0] tgt);
    ucode_t w;
    w.a       = a;
    w.b       = b;
    w.acc     = acc;
    w.acc_idx = ai;
    w.sto     = sto;
    w.sto_idx = si;
    w.seq     = seq;
    w.target  = tgt;
    return w;
  endfunction

  // R*F, R*M, then p x (R*F) + R*M with R*F split into low and high halves
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UW_IDLE;
    unique case (pc)
      5'd0:  w = uw(A_R00, B_F0,  ACC_NOP,  2'd0, STO_NONE, 2'd0, SEQ_BYP,  5'd31);
      5'd1:  w = uw(A_R01, B_F1,  ACC_LOAD, 2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd2:  w = uw(A_R02, B_F2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd3:  w = uw(A_R10, B_F0,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd4:  w = uw(A_R11, B_F1,  ACC_LOAD, 2'd0, STO_RF,   2'd0, SEQ_NEXT, 5'd0);
      5'd5:  w = uw(A_R12, B_F2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd6:  w = uw(A_R20, B_F0,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd7:  w = uw(A_R21, B_F1,  ACC_LOAD, 2'd0, STO_RF,   2'd1, SEQ_NEXT, 5'd0);
      5'd8:  w = uw(A_R22, B_F2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd9:  w = uw(A_R00, B_M0,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd10: w = uw(A_R01, B_M1,  ACC_LOAD, 2'd0, STO_RF,   2'd2, SEQ_NEXT, 5'd0);
      5'd11: w = uw(A_R02, B_M2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd12: w = uw(A_R10, B_M0,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd13: w = uw(A_R11, B_M1,  ACC_LOAD, 2'd0, STO_RM,   2'd0, SEQ_NEXT, 5'd0);
      5'd14: w = uw(A_R12, B_M2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd15: w = uw(A_R20, B_M0,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd16: w = uw(A_R21, B_M1,  ACC_LOAD, 2'd0, STO_RM,   2'd1, SEQ_NEXT, 5'd0);
      5'd17: w = uw(A_R22, B_M2,  ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd18: w = uw(A_P1,  B_LO2, ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd19: w = uw(A_P1,  B_HI2, ACC_LDRM, 2'd0, STO_RM,   2'd2, SEQ_NEXT, 5'd0);
      5'd20: w = uw(A_P2,  B_LO1, ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd21: w = uw(A_P2,  B_HI1, ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd22: w = uw(A_P2,  B_LO0, ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd23: w = uw(A_P2,  B_HI0, ACC_LDRM, 2'd1, STO_TQ,   2'd0, SEQ_NEXT, 5'd0);
      5'd24: w = uw(A_P0,  B_LO2, ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd25: w = uw(A_P0,  B_HI2, ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd26: w = uw(A_P0,  B_LO1, ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd27: w = uw(A_P0,  B_HI1, ACC_LDRM, 2'd2, STO_TQ,   2'd1, SEQ_NEXT, 5'd0);
      5'd28: w = uw(A_P1,  B_LO0, ACC_ADD,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd29: w = uw(A_P1,  B_HI0, ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd30: w = uw(A_P0,  B_F0,  ACC_SUB,  2'd0, STO_NONE, 2'd0, SEQ_NEXT, 5'd0);
      5'd31: w = uw(A_P0,  B_F0,  ACC_NOP,  2'd0, STO_TQ,   2'd2, SEQ_DONE, 5'd0);
    endcase
    return w;
  endfunction

  // floor(v / 2^s + 1/2), then clamp to the signed 32-bit range
  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                   input logic [4:0] s);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] r;
    logic signed [31:0]      res;
    t = v + (ACC_W'(1) <<< (s - 5'd1));
    r = t >>> s;
    if (r > ACC_W'(64'sd2147483647)) begin
      res = 32'sh7fff_ffff;
    end else if (r < -ACC_W'(64'sd2147483648)) begin
      res = 32'sh8000_0000;
    end else begin
      res = r[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/wrench_frame_transform.sv
// Top level: config registers, sample counter, microcode sequencer and output register.
// Depends on wft_pkg and wft_datapath.
// A transform runs the whole program; a bypass beat (same_frame set) jumps from word 0 to the last.
// A 32-word program walks the single shared 16x25 multiplier; no new sample is taken until the
// output register has taken the last result, which frees the sequencer.
// Beats past the sample limit are taken without a stall and dropped.
// Reset (rst_n low, synchronous) clears the counter and limit, loads the default rotation.
`default_nettype none

module wrench_frame_transform (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire wft_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output wft_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [wft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wft_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wft_pkg::*;

  seq_state_t            state_r, state_nxt;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  ucode_t                uw_cur;
  ucode_t                ctl;
  logic [2:0][47:0]      rot_r;
  logic [47:0]           trans_r;
  logic [15:0]           limit_r;
  logic [COUNT_BITS-1:0] cnt_r;
  in_t                   in_r;
  logic [15:0]           idx_r;
  logic                  last_r;
  out_t                  out_r, out_nxt;
  logic                  out_valid_r;
  logic [CMP_W-1:0]      cnt_ext, cnt_inc, lim_ext, eff_lim;
  logic                  have_room;
  logic                  take;
  logic                  slot_free;
  logic                  load_out;
  logic [2:0][23:0]      force_v, torque_v;
  logic [2:0][31:0]      force_q, torque_q;

  assign cnt_ext   = CMP_W'(cnt_r);
  assign cnt_inc   = cnt_ext + CMP_W'(1);
  assign lim_ext   = CMP_W'(limit_r);
  assign eff_lim   = (lim_ext > CNT_MAX) ? CNT_MAX : lim_ext;
  assign have_room = cnt_ext < eff_lim;
  assign slot_free = !out_valid_r || !out_stall;
  assign uw_cur    = ucode(pc_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && have_room) begin
          state_nxt = S_RUN;
          pc_nxt    = '0;
        end
      end
      S_RUN: begin
        unique case (uw_cur.seq)
          SEQ_NEXT: pc_nxt = pc_r + PC_W'(1);
          SEQ_BYP:  pc_nxt = in_r.same_frame ? uw_cur.target : pc_r + PC_W'(1);
          SEQ_DONE: state_nxt = S_FLUSH;
          default:  state_nxt = S_FLUSH;
        endcase
      end
      S_FLUSH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    take     = 1'b0;
    load_out = 1'b0;
    ctl      = UW_IDLE;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        take     = in_valid && have_room;
      end
      S_RUN:   ctl = uw_cur;
      S_FLUSH: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT_ROW0_RST;
      rot_r[1] <= ROT_ROW1_RST;
      rot_r[2] <= ROT_ROW2_RST;
      trans_r  <= '0;
      limit_r  <= '0;
      cnt_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_ROW0:    rot_r[0] <= cfg_data;
        REG_ROT_ROW1:    rot_r[1] <= cfg_data;
        REG_ROT_ROW2:    rot_r[2] <= cfg_data;
        REG_TRANSLATION: trans_r  <= cfg_data;
        REG_SAMPLE_LIMIT: begin
          limit_r <= cfg_data[15:0];
          cnt_r   <= '0;
        end
        default: ;
      endcase
    end else if (take) begin
      cnt_r <= COUNT_BITS'(cnt_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r   <= in_data;
      idx_r  <= cnt_ext[15:0];
      last_r <= (cnt_inc == eff_lim);
    end
  end

  assign force_v[0]  = in_r.force_x;
  assign force_v[1]  = in_r.force_y;
  assign force_v[2]  = in_r.force_z;
  assign torque_v[0] = in_r.torque_x;
  assign torque_v[1] = in_r.torque_y;
  assign torque_v[2] = in_r.torque_z;

  wft_datapath u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .rot      (rot_r),
    .trans    (trans_r),
    .force_v  (force_v),
    .torque_v (torque_v),
    .force_q  (force_q),
    .torque_q (torque_q)
  );

  always_comb begin
    if (in_r.same_frame) begin
      out_nxt.out_force_x  = {{8{in_r.force_x[23]}},  in_r.force_x};
      out_nxt.out_force_y  = {{8{in_r.force_y[23]}},  in_r.force_y};
      out_nxt.out_force_z  = {{8{in_r.force_z[23]}},  in_r.force_z};
      out_nxt.out_torque_x = {{8{in_r.torque_x[23]}}, in_r.torque_x};
      out_nxt.out_torque_y = {{8{in_r.torque_y[23]}}, in_r.torque_y};
      out_nxt.out_torque_z = {{8{in_r.torque_z[23]}}, in_r.torque_z};
    end else begin
      out_nxt.out_force_x  = force_q[0];
      out_nxt.out_force_y  = force_q[1];
      out_nxt.out_force_z  = force_q[2];
      out_nxt.out_torque_x = torque_q[0];
      out_nxt.out_torque_y = torque_q[1];
      out_nxt.out_torque_z = torque_q[2];
    end
    out_nxt.out_stamp    = in_r.time_stamp;
    out_nxt.sample_index = idx_r;
    out_nxt.last_sample  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/wft_datapath.sv
// Shared 16x25 multiplier, 64-bit accumulator and result registers, driven by one control word.
// Depends on wft_pkg for the control word and rounding helper.
`default_nettype none

module wft_datapath (
  input  wire logic                  clk,
  input  wire wft_pkg::ucode_t       ctl,
  input  wire logic [2:0][47:0]      rot,
  input  wire logic [47:0]           trans,
  input  wire logic [2:0][23:0]      force_v,
  input  wire logic [2:0][23:0]      torque_v,
  output logic      [2:0][31:0]      force_q,
  output logic      [2:0][31:0]      torque_q
);
  import wft_pkg::*;

  logic signed [15:0]       r_ent [9];
  logic signed [15:0]       p_ent [3];
  logic signed [15:0]       a_val;
  logic signed [24:0]       b_val;
  logic                     b_hi;
  logic signed [40:0]       mul;
  logic signed [ACC_W-1:0]  mul_ext;
  logic signed [ACC_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RF_W-1:0]   rf_r [3];
  logic signed [RF_W-1:0]   rm_r [3];
  logic signed [31:0]       fo_r [3];
  logic signed [31:0]       tq_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r_ent[3*i+j] = rot[i][16*j +: 16];
      end
      p_ent[i] = trans[16*i +: 16];
    end
  end

  always_comb begin
    unique case (ctl.a)
      A_R00:   a_val = r_ent[0];
      A_R01:   a_val = r_ent[1];
      A_R02:   a_val = r_ent[2];
      A_R10:   a_val = r_ent[3];
      A_R11:   a_val = r_ent[4];
      A_R12:   a_val = r_ent[5];
      A_R20:   a_val = r_ent[6];
      A_R21:   a_val = r_ent[7];
      A_R22:   a_val = r_ent[8];
      A_P0:    a_val = p_ent[0];
      A_P1:    a_val = p_ent[1];
      A_P2:    a_val = p_ent[2];
      default: a_val = '0;
    endcase
  end

  always_comb begin
    b_hi = 1'b0;
    unique case (ctl.b)
      B_F0:    b_val = {force_v[0][23], force_v[0]};
      B_F1:    b_val = {force_v[1][23], force_v[1]};
      B_F2:    b_val = {force_v[2][23], force_v[2]};
      B_M0:    b_val = {torque_v[0][23], torque_v[0]};
      B_M1:    b_val = {torque_v[1][23], torque_v[1]};
      B_M2:    b_val = {torque_v[2][23], torque_v[2]};
      B_LO0:   b_val = {4'b0, rf_r[0][SPLIT-1:0]};
      B_LO1:   b_val = {4'b0, rf_r[1][SPLIT-1:0]};
      B_LO2:   b_val = {4'b0, rf_r[2][SPLIT-1:0]};
      B_HI0: begin
        b_val = 25'(rf_r[0] >>> SPLIT);
        b_hi  = 1'b1;
      end
      B_HI1: begin
        b_val = 25'(rf_r[1] >>> SPLIT);
        b_hi  = 1'b1;
      end
      B_HI2: begin
        b_val = 25'(rf_r[2] >>> SPLIT);
        b_hi  = 1'b1;
      end
      default: b_val = '0;
    endcase
  end

  assign mul      = a_val * b_val;
  assign mul_ext  = ACC_W'(mul);
  assign prod_nxt = b_hi ? (mul_ext <<< SPLIT) : mul_ext;

  always_comb begin
    unique case (ctl.acc)
      ACC_NOP:  acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      ACC_SUB:  acc_nxt = acc_r - prod_r;
      ACC_LDRM: acc_nxt = (ACC_W'(rm_r[ctl.acc_idx]) <<< 12) + prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    unique case (ctl.sto)
      STO_NONE: ;
      STO_RF: begin
        rf_r[ctl.sto_idx] <= acc_r[RF_W-1:0];
        fo_r[ctl.sto_idx] <= round_sat(acc_r, FRAC_FORCE);
      end
      STO_RM:   rm_r[ctl.sto_idx] <= acc_r[RF_W-1:0];
      STO_TQ:   tq_r[ctl.sto_idx] <= round_sat(acc_r, FRAC_TORQUE);
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      force_q[i]  = fo_r[i];
      torque_q[i] = tq_r[i];
    end
  end

endmodule

`default_nettype wire

### rtl/wft_checker.sv
// Port-level checks of the wrench frame transform, bound to the top level.
// Depends on wft_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wft_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire wft_pkg::out_t out_data
);
  import wft_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_result_frees_input, clk, rst_n, $rose(out_valid), !in_stall)
  `ASSERT_IMPL(a_stall_after_beat, clk, rst_n, $rose(in_stall), $past(in_valid))
  `ASSERT_NEXT(a_run_min_length, clk, rst_n, $rose(in_stall), in_stall)

endmodule

bind wrench_frame_transform wft_checker u_wft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
